// ----- sv/pfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfsa_pkg
// Shared types and constants for the paged fixed-slot allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

  localparam int PAGE_LIMIT         = 16;
  localparam int SLOTS_PER_PAGE_MAX = 16;
  localparam int STACK_DEPTH        = PAGE_LIMIT * SLOTS_PER_PAGE_MAX;

  localparam int PAGE_W  = $clog2(PAGE_LIMIT);
  localparam int IDX_W   = $clog2(SLOTS_PER_PAGE_MAX);
  localparam int ID_W    = PAGE_W + IDX_W;
  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int TOP_W   = ADDR_W + 1;
  localparam int OFF_W   = 16;
  localparam int CFG_W   = 12;
  localparam int CNT_W   = 9;
  localparam int TOT_W   = 32;
  localparam int PGC_W   = 5;

  localparam logic [2:0] CFG_OBJECTS_PER_PAGE = 3'd0;
  localparam logic [2:0] CFG_MAX_PAGES        = 3'd1;
  localparam logic [2:0] CFG_DEBUG_ON         = 3'd2;
  localparam logic [2:0] CFG_FIRST_OFFSET     = 3'd3;
  localparam logic [2:0] CFG_SLOT_STRIDE      = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PAGES = 2'd1;
  localparam logic [1:0] ST_MULTI    = 2'd2;
  localparam logic [1:0] ST_BAD_BND  = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [OFF_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] quot;
    logic [CFG_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- sv/pfsa_div.sv -----
// ----------------------------------------------------------------------------
// pfsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfsa_div
  import pfsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(OFF_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [OFF_W-1:0]  quot_r;
  logic [CFG_W-1:0]  rem_r;
  logic [CFG_W-1:0]  dvs_r;

  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;
  logic              ge;
  logic [CFG_W-1:0]  rem_nxt;

  assign trial   = {rem_r, quot_r[OFF_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(OFF_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[OFF_W-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- sv/paged_fixed_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// paged_fixed_slot_allocator_top
// Fixed-size slot allocator: LIFO free-slot stack over claimed pages.
//
// channel  ports                                   transfer
// input    start, busy, in_command, in_free_*      start & !busy
// result   out_valid, out_*                        out_valid, one cycle
// config   cfg_we, cfg_index, cfg_wdata            cfg_we
//
// Allocate: S_POP reads the stack top and S_ALLOC registers the result and its
// strobe; when the stack is empty a new page is first loaded in S_LOAD, slot by
// slot; with no page left the strobe comes in the cycle after start.
// Free: the divider runs, then a push; a bad boundary answers when the divider is
// done; a checked free also scans the stack one entry per cycle before the push.
// After reset the first page is loaded with busy high.
// Results cannot be stalled; the strobe comes with busy already low.
// ----------------------------------------------------------------------------
module paged_fixed_slot_allocator_top
  import pfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_command,
  input  logic [PAGE_W-1:0] in_free_page,
  input  logic [OFF_W-1:0]  in_free_offset,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [PAGE_W-1:0] out_alloc_page,
  output logic [OFF_W-1:0]  out_alloc_offset,
  output logic [CNT_W-1:0]  out_in_use_count,
  output logic [CNT_W-1:0]  out_free_count,
  output logic [PGC_W-1:0]  out_pages_count,
  output logic [CNT_W-1:0]  out_peak_in_use,
  output logic [TOT_W-1:0]  out_total_allocs,
  output logic [TOT_W-1:0]  out_total_frees,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam logic [4:0] OPP_RESET = 5'd4;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_POP   = 7'b0000100,
    S_ALLOC = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_PUSH  = 7'b1000000
  } state_t;

  // configuration
  logic [4:0]       opp_r;
  logic [4:0]       maxp_r;
  logic             dbg_r;
  logic [CFG_W-1:0] first_r;
  logic [CFG_W-1:0] stride_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opp_r    <= OPP_RESET;
      maxp_r   <= 5'd0;
      dbg_r    <= 1'b1;
      first_r  <= 12'd8;
      stride_r <= 12'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBJECTS_PER_PAGE: opp_r    <= cfg_wdata[4:0];
        CFG_MAX_PAGES:        maxp_r   <= cfg_wdata[4:0];
        CFG_DEBUG_ON:         dbg_r    <= cfg_wdata[0];
        CFG_FIRST_OFFSET:     first_r  <= cfg_wdata;
        CFG_SLOT_STRIDE:      stride_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [4:0]       eff_opp;
  logic [CFG_W-1:0] eff_stride;
  logic [PGC_W-1:0] eff_limit;

  assign eff_opp    = (opp_r == 5'd0) ? 5'd1 :
                      (opp_r > 5'(SLOTS_PER_PAGE_MAX)) ? 5'(SLOTS_PER_PAGE_MAX) : opp_r;
  assign eff_stride = (stride_r == '0) ? CFG_W'(1) : stride_r;
  assign eff_limit  = (maxp_r == 5'd0 || maxp_r > 5'(PAGE_LIMIT)) ?
                      PGC_W'(PAGE_LIMIT) : maxp_r;

  // state
  state_t            state_r, state_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [PGC_W-1:0]  pages_r, pages_nxt;
  logic [CNT_W-1:0]  in_use_r, in_use_nxt;
  logic [CNT_W-1:0]  peak_r, peak_nxt;
  logic [TOT_W-1:0]  allocs_r, allocs_nxt;
  logic [TOT_W-1:0]  frees_r, frees_nxt;
  logic              load_alloc_r, load_alloc_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic [TOP_W-1:0]  scan_k_r, scan_k_nxt;
  logic              scan_vld_r, scan_vld_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [PAGE_W-1:0] fpage_r, fpage_nxt;
  logic [OFF_W-1:0]  foff_r, foff_nxt;
  logic [ID_W-1:0]   slot_r, slot_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [PAGE_W-1:0] apage_r, apage_nxt;
  logic [OFF_W-1:0]  aoff_r, aoff_nxt;

  // stack memory
  logic [ID_W-1:0]   stack_mem [STACK_DEPTH];
  logic [ID_W-1:0]   mem_q_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [ID_W-1:0]   mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= stack_mem[mem_raddr];
    end
  end

  div_req_t div_req;
  div_rsp_t div_rsp;

  pfsa_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  logic              accept;
  logic [OFF_W-1:0]  mul_p;
  logic              chk_ok;
  logic [ID_W-1:0]   chk_slot;
  logic [TOP_W-1:0]  top_dec;

  assign accept   = start && (state_r == S_IDLE);
  assign mul_p    = {{(OFF_W-IDX_W){1'b0}}, mem_q_r[IDX_W-1:0]} *
                    {{(OFF_W-CFG_W){1'b0}}, eff_stride};
  assign chk_slot = {fpage_r, div_rsp.quot[IDX_W-1:0]};
  assign chk_ok   = ({1'b0, fpage_r} < pages_r) &&
                    (foff_r >= {{(OFF_W-CFG_W){1'b0}}, first_r}) &&
                    (div_rsp.rem == '0) &&
                    (div_rsp.quot < {{(OFF_W-5){1'b0}}, eff_opp});
  assign top_dec  = top_r - 1'b1;

  assign div_req.start    = accept && (in_command == CMD_FREE);
  assign div_req.dividend = in_free_offset - {{(OFF_W-CFG_W){1'b0}}, first_r};
  assign div_req.divisor  = eff_stride;

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    pages_nxt      = pages_r;
    in_use_nxt     = in_use_r;
    peak_nxt       = peak_r;
    allocs_nxt     = allocs_r;
    frees_nxt      = frees_r;
    load_alloc_nxt = load_alloc_r;
    page_nxt       = page_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    scan_k_nxt     = scan_k_r;
    scan_vld_nxt   = 1'b0;
    out_valid_nxt  = 1'b0;
    fpage_nxt      = fpage_r;
    foff_nxt       = foff_r;
    slot_nxt       = slot_r;
    status_nxt     = status_r;
    apage_nxt      = apage_r;
    aoff_nxt       = aoff_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = top_r[ADDR_W-1:0];
    mem_raddr      = top_dec[ADDR_W-1:0];
    mem_wdata      = {page_r, cnt_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_OK;
          apage_nxt  = '0;
          aoff_nxt   = '0;
          if (in_command == CMD_FREE) begin
            fpage_nxt = in_free_page;
            foff_nxt  = in_free_offset;
            state_nxt = S_DIV;
          end else if (top_r != '0) begin
            state_nxt = S_POP;
          end else if (pages_r < eff_limit) begin
            page_nxt       = pages_r[PAGE_W-1:0];
            pages_nxt      = pages_r + 1'b1;
            cnt_nxt        = '0;
            last_nxt       = IDX_W'(eff_opp - 5'd1);
            load_alloc_nxt = 1'b1;
            state_nxt      = S_LOAD;
          end else begin
            status_nxt    = ST_NO_PAGES;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_LOAD: begin
        if (!top_r[TOP_W-1]) begin
          mem_we  = 1'b1;
          top_nxt = top_r + 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == last_r) begin
          state_nxt = load_alloc_r ? S_POP : S_IDLE;
        end
      end
      S_POP: begin
        mem_re    = 1'b1;
        top_nxt   = top_dec;
        state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        apage_nxt  = mem_q_r[ID_W-1:IDX_W];
        aoff_nxt   = {{(OFF_W-CFG_W){1'b0}}, first_r} + mul_p;
        in_use_nxt = (in_use_r == '1) ? in_use_r : in_use_r + 1'b1;
        peak_nxt   = (in_use_nxt > peak_r) ? in_use_nxt : peak_r;
        allocs_nxt = allocs_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          slot_nxt = chk_slot;
          if (!dbg_r) begin
            state_nxt = S_PUSH;
          end else if (!chk_ok) begin
            status_nxt    = ST_BAD_BND;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            scan_k_nxt = '0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_raddr = scan_k_r[ADDR_W-1:0];
        if (scan_vld_r && mem_q_r == slot_r) begin
          status_nxt    = ST_MULTI;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (scan_k_r < top_r) begin
          mem_re       = 1'b1;
          scan_vld_nxt = 1'b1;
          scan_k_nxt   = scan_k_r + 1'b1;
        end else if (!scan_vld_r) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        mem_wdata = slot_r;
        if (!top_r[TOP_W-1]) begin
          mem_we  = 1'b1;
          top_nxt = top_r + 1'b1;
        end
        in_use_nxt    = (in_use_r == '0) ? in_use_r : in_use_r - 1'b1;
        frees_nxt     = frees_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      top_r        <= '0;
      pages_r      <= PGC_W'(1);
      in_use_r     <= '0;
      peak_r       <= '0;
      allocs_r     <= '0;
      frees_r      <= '0;
      load_alloc_r <= 1'b0;
      page_r       <= '0;
      cnt_r        <= '0;
      last_r       <= IDX_W'(OPP_RESET - 5'd1);
      scan_k_r     <= '0;
      scan_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      top_r        <= top_nxt;
      pages_r      <= pages_nxt;
      in_use_r     <= in_use_nxt;
      peak_r       <= peak_nxt;
      allocs_r     <= allocs_nxt;
      frees_r      <= frees_nxt;
      load_alloc_r <= load_alloc_nxt;
      page_r       <= page_nxt;
      cnt_r        <= cnt_nxt;
      last_r       <= last_nxt;
      scan_k_r     <= scan_k_nxt;
      scan_vld_r   <= scan_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fpage_r  <= fpage_nxt;
    foff_r   <= foff_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    apage_r  <= apage_nxt;
    aoff_r   <= aoff_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_alloc_page   = apage_r;
  assign out_alloc_offset = aoff_r;
  assign out_in_use_count = in_use_r;
  assign out_free_count   = top_r;
  assign out_pages_count  = pages_r;
  assign out_peak_in_use  = peak_r;
  assign out_total_allocs = allocs_r;
  assign out_total_frees  = frees_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither busy nor answered");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TOP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pages_r != '0) && (pages_r <= PGC_W'(PAGE_LIMIT)))
    else $error("page count out of range");

  a_peak_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (peak_r >= in_use_r))
    else $error("peak below in-use count");

endmodule

// ----- test/pfsa_checker.sv -----
// ----------------------------------------------------------------------------
// pfsa_checker
// Watches the command, result and register ports of the slot allocator,
// keeps its own copy of the free-slot stack, page count and statistics,
// predicts one result per accepted command and compares it field by field
// with each strobed result, oldest first.
// ----------------------------------------------------------------------------
module pfsa_checker
  import pfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_command,
  input  logic [PAGE_W-1:0] in_free_page,
  input  logic [OFF_W-1:0]  in_free_offset,
  input  logic              out_valid,
  input  logic [1:0]        out_status,
  input  logic [PAGE_W-1:0] out_alloc_page,
  input  logic [OFF_W-1:0]  out_alloc_offset,
  input  logic [CNT_W-1:0]  out_in_use_count,
  input  logic [CNT_W-1:0]  out_free_count,
  input  logic [PGC_W-1:0]  out_pages_count,
  input  logic [CNT_W-1:0]  out_peak_in_use,
  input  logic [TOT_W-1:0]  out_total_allocs,
  input  logic [TOT_W-1:0]  out_total_frees,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                checked_count
);

  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  in_use;
    logic [CNT_W-1:0]  free_cnt;
    logic [PGC_W-1:0]  pages;
    logic [CNT_W-1:0]  peak;
    logic [TOT_W-1:0]  allocs;
    logic [TOT_W-1:0]  frees;
  } slot_reply_t;

  logic [4:0]       reg_opp;
  logic [4:0]       reg_max_pages;
  logic             reg_debug;
  logic [CFG_W-1:0] reg_first;
  logic [CFG_W-1:0] reg_stride;

  logic [ID_W-1:0]  free_slots [STACK_DEPTH];
  logic [TOP_W-1:0] slot_top;
  logic [PGC_W-1:0] pages_claimed;
  logic [CNT_W-1:0] in_use;
  logic [CNT_W-1:0] peak_in_use;
  logic [TOT_W-1:0] alloc_total;
  logic [TOT_W-1:0] free_total;

  slot_reply_t awaited_replies [$];
  int          n_fail;
  int          n_checked;

  function automatic int unsigned slots_per_page();
    if (reg_opp == 0) return 1;
    if (reg_opp > SLOTS_PER_PAGE_MAX) return SLOTS_PER_PAGE_MAX;
    return reg_opp;
  endfunction

  task automatic push_slot(input int unsigned id);
    if (slot_top < STACK_DEPTH) begin
      free_slots[slot_top] = ID_W'(id);
      slot_top++;
    end
  endtask

  task automatic load_page(input int unsigned page);
    int unsigned n;
    n = slots_per_page();
    for (int unsigned i = 0; i < n; i++) push_slot(page * SLOTS_PER_PAGE_MAX + i);
  endtask

  task automatic reset_allocator();
    reg_opp       = 5'd4;
    reg_max_pages = 5'd0;
    reg_debug     = 1'b1;
    reg_first     = CFG_W'(8);
    reg_stride    = CFG_W'(16);
    slot_top      = '0;
    pages_claimed = PGC_W'(1);
    in_use        = '0;
    peak_in_use   = '0;
    alloc_total   = '0;
    free_total    = '0;
    load_page(0);
  endtask

  task automatic apply_command(input logic cmd, input logic [PAGE_W-1:0] pg,
                               input logic [OFF_W-1:0] off);
    slot_reply_t      r;
    int unsigned      stride, limit, idx, id;
    logic [OFF_W-1:0] rel;
    bit               ok;
    r      = '0;
    ok     = 1'b1;
    stride = (reg_stride == 0) ? 1 : reg_stride;
    limit  = (reg_max_pages == 0 || reg_max_pages > PAGE_LIMIT) ? PAGE_LIMIT : reg_max_pages;
    if (cmd == CMD_ALLOC) begin
      if (slot_top == 0) begin
        if (pages_claimed < limit) begin
          load_page(pages_claimed);
          pages_claimed++;
        end else begin
          ok       = 1'b0;
          r.status = ST_NO_PAGES;
        end
      end
      if (ok && slot_top > 0) begin
        slot_top--;
        id       = free_slots[slot_top];
        r.page   = PAGE_W'(id / SLOTS_PER_PAGE_MAX);
        r.offset = OFF_W'(reg_first + (id % SLOTS_PER_PAGE_MAX) * stride);
        if (in_use != {CNT_W{1'b1}}) in_use++;
        if (in_use > peak_in_use) peak_in_use = in_use;
        alloc_total++;
      end
    end else begin
      rel = off - OFF_W'(reg_first);
      idx = rel / stride;
      if (reg_debug) begin
        if (!(pg < pages_claimed && off >= reg_first && (rel % stride) == 0 &&
              idx < slots_per_page())) begin
          ok       = 1'b0;
          r.status = ST_BAD_BND;
        end else begin
          id = pg * SLOTS_PER_PAGE_MAX + idx;
          for (int unsigned k = 0; k < slot_top; k++) begin
            if (ok && free_slots[k] == ID_W'(id)) begin
              ok       = 1'b0;
              r.status = ST_MULTI;
            end
          end
        end
      end
      if (ok) begin
        push_slot(pg * SLOTS_PER_PAGE_MAX + idx % SLOTS_PER_PAGE_MAX);
        if (in_use != 0) in_use--;
        free_total++;
      end
    end
    r.in_use   = in_use;
    r.free_cnt = CNT_W'(slot_top);
    r.pages    = pages_claimed;
    r.peak     = peak_in_use;
    r.allocs   = alloc_total;
    r.frees    = free_total;
    awaited_replies.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_fail < MAX_PRINTS)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h", $time, n_checked, what,
               got, want);
    n_fail++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_reply();
    slot_reply_t w;
    if (awaited_replies.size() == 0) begin
      report_mismatch("unexpected transfer, status", 32'(out_status), 32'(0));
      return;
    end
    w = awaited_replies.pop_front();
    check_field("status", 32'(out_status), 32'(w.status));
    check_field("alloc_page", 32'(out_alloc_page), 32'(w.page));
    check_field("alloc_offset", 32'(out_alloc_offset), 32'(w.offset));
    check_field("in_use_count", 32'(out_in_use_count), 32'(w.in_use));
    check_field("free_count", 32'(out_free_count), 32'(w.free_cnt));
    check_field("pages_count", 32'(out_pages_count), 32'(w.pages));
    check_field("peak_in_use", 32'(out_peak_in_use), 32'(w.peak));
    check_field("total_allocs", out_total_allocs, w.allocs);
    check_field("total_frees", out_total_frees, w.frees);
    n_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_allocator();
      awaited_replies.delete();
    end else begin
      if (out_valid === 1'b1) check_reply();
      if (start && !busy) apply_command(in_command, in_free_page, in_free_offset);
      if (cfg_we) begin
        case (cfg_index)
          CFG_OBJECTS_PER_PAGE: reg_opp       = cfg_wdata[4:0];
          CFG_MAX_PAGES:        reg_max_pages = cfg_wdata[4:0];
          CFG_DEBUG_ON:         reg_debug     = cfg_wdata[0];
          CFG_FIRST_OFFSET:     reg_first     = cfg_wdata;
          CFG_SLOT_STRIDE:      reg_stride    = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count    <= n_fail;
    pending       <= awaited_replies.size();
    checked_count <= n_checked;
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives the slot allocator with a directed opening (boundary, unclaimed
// page, double free, page claim, page limit, register extremes) and then four
// random phases under different register settings and sender idle rates.
// Frees mostly return slots that were handed out, with double frees, off-grid
// offsets and noise mixed in. pfsa_checker does all result checking.
// ----------------------------------------------------------------------------
module tb
  import pfsa_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  offset;
  } slot_handle_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_command;
  logic [PAGE_W-1:0] in_free_page;
  logic [OFF_W-1:0]  in_free_offset;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [PAGE_W-1:0] out_alloc_page;
  logic [OFF_W-1:0]  out_alloc_offset;
  logic [CNT_W-1:0]  out_in_use_count;
  logic [CNT_W-1:0]  out_free_count;
  logic [PGC_W-1:0]  out_pages_count;
  logic [CNT_W-1:0]  out_peak_in_use;
  logic [TOT_W-1:0]  out_total_allocs;
  logic [TOT_W-1:0]  out_total_frees;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  int fail_count;
  int pending;
  int checked_count;

  int unsigned      idle_pct;
  int unsigned      sent;
  int unsigned      settings_used;
  logic [4:0]       cur_opp;
  logic [CFG_W-1:0] cur_first;
  logic [CFG_W-1:0] cur_stride;

  slot_handle_t live_slots [$];
  slot_handle_t freed_slots [$];
  logic         issued_cmds [$];
  logic         was_alloc;

  paged_fixed_slot_allocator_top dut (.*);

  pfsa_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Handles are harvested on the falling edge so the stimulus never races them.
  always @(negedge clk) begin
    if (rst_n && out_valid && issued_cmds.size() > 0) begin
      was_alloc = (issued_cmds.pop_front() == CMD_ALLOC);
      if (was_alloc && out_status == ST_OK) begin
        live_slots.push_back('{out_alloc_page, out_alloc_offset});
        if (live_slots.size() > 300) live_slots.delete(0);
      end
    end
    if (rst_n && start && !busy) issued_cmds.push_back(in_command);
  end

  task automatic send_item(input logic cmd, input logic [PAGE_W-1:0] pg,
                           input logic [OFF_W-1:0] off);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_free_page   <= pg;
    in_free_offset <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_layout(input logic [4:0] opp, input logic [4:0] max_pg,
                            input logic dbg, input logic [CFG_W-1:0] first,
                            input logic [CFG_W-1:0] stride);
    wait_idle();
    write_reg(CFG_OBJECTS_PER_PAGE, CFG_W'(opp));
    write_reg(CFG_MAX_PAGES, CFG_W'(max_pg));
    write_reg(CFG_DEBUG_ON, CFG_W'(dbg));
    write_reg(CFG_FIRST_OFFSET, first);
    write_reg(CFG_SLOT_STRIDE, stride);
    cfg_we     <= 1'b0;
    cur_opp    = opp;
    cur_first  = first;
    cur_stride = stride;
    settings_used++;
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned alloc_pct);
    int unsigned       roll;
    int unsigned       pick;
    logic              cmd;
    logic [PAGE_W-1:0] pg;
    logic [OFF_W-1:0]  off;
    repeat (count) begin
      cmd  = CMD_FREE;
      pg   = PAGE_W'($urandom);
      off  = OFF_W'($urandom);
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        cmd = CMD_ALLOC;
      end else begin
        roll = $urandom_range(99);
        if (roll < 60 && live_slots.size() > 0) begin
          pick = $urandom_range(live_slots.size() - 1);
          pg   = live_slots[pick].page;
          off  = live_slots[pick].offset;
          freed_slots.push_back(live_slots[pick]);
          live_slots.delete(pick);
          if (freed_slots.size() > 16) freed_slots.delete(0);
        end else if (roll < 75 && freed_slots.size() > 0) begin
          // double free of a recently returned slot
          pick = $urandom_range(freed_slots.size() - 1);
          pg   = freed_slots[pick].page;
          off  = freed_slots[pick].offset;
        end else if (roll < 92) begin
          // on the slot grid, one index past the page end included
          pg  = $urandom_range(1) ? PAGE_W'($urandom_range(3)) : PAGE_W'($urandom_range(15));
          off = OFF_W'(cur_first + $urandom_range(cur_opp) * cur_stride);
        end
      end
      send_item(cmd, pg, off);
    end
  endtask

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) stall = 0;
      else stall++;
    end
    $display("FAIL paged_fixed_slot_allocator_top");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = CMD_ALLOC;
    in_free_page   = '0;
    in_free_offset = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_OBJECTS_PER_PAGE;
    cfg_wdata      = '0;
    idle_pct       = 20;
    sent           = 0;
    settings_used  = 1;
    cur_opp        = 5'd4;
    cur_first      = CFG_W'(8);
    cur_stride     = CFG_W'(16);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset layout: 4 slots per page, first at 8, stride 16, checks on
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_FREE, PAGE_W'(0), OFF_W'(56));
    send_item(CMD_FREE, PAGE_W'(0), OFF_W'(56));
    send_item(CMD_FREE, PAGE_W'(0), OFF_W'(57));
    send_item(CMD_FREE, PAGE_W'(0), OFF_W'(0));
    send_item(CMD_FREE, PAGE_W'(1), OFF_W'(8));
    send_item(CMD_FREE, PAGE_W'(0), OFF_W'(72));
    send_item(CMD_FREE, PAGE_W'(15), 16'hFFFF);
    repeat (5) send_item(CMD_ALLOC, PAGE_W'(15), 16'hFFFF);

    // zero slot count and stride, two-page limit, unchecked frees
    set_layout(5'd0, 5'd2, 1'b0, CFG_W'(4095), CFG_W'(0));
    repeat (4) send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_FREE, PAGE_W'(15), OFF_W'(0));
    send_item(CMD_FREE, PAGE_W'(0), 16'hFFFF);
    send_item(CMD_FREE, PAGE_W'(7), 16'h8000);

    // oversized slot count and page limit, widest stride
    set_layout(5'd31, 5'd31, 1'b1, CFG_W'(0), CFG_W'(4095));
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_FREE, PAGE_W'(15), OFF_W'(61425));
    send_item(CMD_FREE, PAGE_W'(0), OFF_W'(4095));

    set_layout(5'd4, 5'd0, 1'b1, CFG_W'(8), CFG_W'(16));
    random_phase(480, 50);

    idle_pct = 86;
    set_layout(5'd16, 5'd16, 1'b0, CFG_W'(0), CFG_W'(4095));
    random_phase(480, 35);

    idle_pct = 0;
    set_layout(5'd1, 5'd1, 1'b1, CFG_W'(4095), CFG_W'(1));
    random_phase(480, 65);

    set_layout(5'd7, 5'd3, 1'b1, CFG_W'(100), CFG_W'(24));
    random_phase(490, 50);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d commands under %0d register settings", sent, settings_used);
    $display("%0d results compared, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS paged_fixed_slot_allocator_top");
    end else begin
      $display("FAIL paged_fixed_slot_allocator_top");
    end
    $finish;
  end

endmodule
